// ===== rtl/dirty_page_tracker_assert.svh =====
// Assertion macros for the checker file of the dirty page tracker
`ifndef DIRTY_PAGE_TRACKER_ASSERT_SVH
`define DIRTY_PAGE_TRACKER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define DPT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dirty_page_tracker: check failed");

// Next-cycle implication, sampled on clk, off during reset
`define DPT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dirty_page_tracker: check failed");

`endif

// ===== rtl/dpt_pkg.sv =====
// Shared types and constants of the dirty page tracker
package dpt_pkg;

  localparam int ADDR_W  = 27;
  localparam int WIDX_W  = 9;
  localparam int PAGE_NW = 15;
  localparam int COUNT_W = 16;
  localparam int CMP_W   = 20;

  typedef struct packed {
    logic clear_step;
    logic accept;
    logic mark_done;
    logic drain_empty;
    logic drain_start;
    logic drain_emit;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_drain;
    logic drain_empty;
    logic slot_free;
    logic work_last;
  } sts_t;

endpackage

// ===== rtl/dpt_ctrl.sv =====
// Controller state machine of the dirty page tracker
module dpt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  dpt_pkg::sts_t sts,
  output dpt_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (!sts.is_drain) begin
          if (sts.slot_free) begin
            cmd.mark_done = 1'b1;
            state_next    = ST_IDLE;
          end
        end else if (sts.drain_empty) begin
          if (sts.slot_free) begin
            cmd.drain_empty = 1'b1;
            state_next      = ST_IDLE;
          end
        end else begin
          cmd.drain_start = 1'b1;
          state_next      = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts.slot_free) begin
          cmd.drain_emit = 1'b1;
          if (sts.work_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/dpt_datapath.sv =====
// Datapath of the dirty page tracker: bitmap memory, count, drain word and result register
module dpt_datapath #(
  parameter int PAGE_BITS = 12,
  parameter int MAX_PAGES = 32768,
  parameter int WORD_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dpt_pkg::cmd_t                 cmd,
  output dpt_pkg::sts_t                 sts,
  input  logic                          cfg_we,
  input  logic [dpt_pkg::COUNT_W-1:0]   cfg_data,
  input  logic                          mode,
  input  logic [dpt_pkg::ADDR_W-1:0]    address,
  input  logic [dpt_pkg::WIDX_W-1:0]    word_index,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [dpt_pkg::PAGE_NW-1:0]   page_number,
  output logic                          page_valid,
  output logic                          newly_dirty,
  output logic                          out_of_range,
  output logic [dpt_pkg::COUNT_W-1:0]   dirty_count,
  output logic                          last
);

  localparam int WORD_COUNT = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int WB_LOG     = $clog2(WORD_BITS);
  localparam int PAGE_W     = dpt_pkg::ADDR_W - PAGE_BITS;
  localparam int CW         = dpt_pkg::CMP_W;
  localparam int NW         = dpt_pkg::COUNT_W;
  localparam int PW         = dpt_pkg::PAGE_NW;
  localparam logic [NW-1:0] MAX_C      = NW'(MAX_PAGES);
  localparam logic [CW-1:0] WCOUNT_C   = CW'(WORD_COUNT);
  localparam logic [AW-1:0] CLR_LAST_C = AW'(WORD_COUNT - 1);

  logic [WORD_BITS-1:0] mem [WORD_COUNT];
  logic [WORD_BITS-1:0] rd_data, wr_data, work, bit_mask, low, rem;
  logic [AW-1:0]        clr_addr, rd_addr, wr_addr, mark_addr, drain_addr;
  logic                 wr_en;
  logic                 mode_q;
  logic [PAGE_W-1:0]    page_q;
  logic [dpt_pkg::WIDX_W-1:0] widx_q;
  logic [CW-1:0]        page_in_ext, widx_in_ext, page_ext, widx_ext, drain_page;
  logic [WB_LOG-1:0]    bit_sel, bidx;
  logic [NW-1:0]        arena_pages, dirty_total, total_next, limit;
  logic                 oor, fresh, idx_oor, load;

  // read address straight from the input item
  assign page_in_ext = CW'(address[dpt_pkg::ADDR_W-1:PAGE_BITS]);
  assign widx_in_ext = CW'(word_index);
  assign rd_addr     = mode ? widx_in_ext[AW-1:0] : page_in_ext[WB_LOG +: AW];

  assign page_ext   = CW'(page_q);
  assign widx_ext   = CW'(widx_q);
  assign mark_addr  = page_ext[WB_LOG +: AW];
  assign drain_addr = widx_ext[AW-1:0];
  assign bit_sel    = page_q[WB_LOG-1:0];

  assign limit    = (arena_pages < MAX_C) ? arena_pages : MAX_C;
  assign oor      = (page_ext >= CW'(limit));
  assign bit_mask = WORD_BITS'(1) << bit_sel;
  assign fresh    = !oor && ((rd_data & bit_mask) == '0);
  assign idx_oor  = (widx_ext >= WCOUNT_C);

  // lowest set bit of the drain word, and the word without it
  assign low = work & (~work + WORD_BITS'(1));
  assign rem = work & (work - WORD_BITS'(1));

  always_comb begin
    bidx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (low[i]) begin
        bidx = bidx | WB_LOG'(i);
      end
    end
  end

  assign drain_page = (widx_ext << WB_LOG) | CW'(bidx);

  always_comb begin
    total_next = dirty_total;
    if (cmd.mark_done && fresh && (dirty_total < MAX_C)) begin
      total_next = dirty_total + NW'(1);
    end
    if (cmd.drain_emit && (dirty_total != '0)) begin
      total_next = dirty_total - NW'(1);
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = '0;
    if (cmd.clear_step) begin
      wr_en = 1'b1;
    end else if (cmd.mark_done) begin
      wr_en   = !oor;
      wr_addr = mark_addr;
      wr_data = rd_data | bit_mask;
    end else if (cmd.drain_start) begin
      wr_en   = 1'b1;
      wr_addr = drain_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.accept) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_q <= mode;
      page_q <= address[dpt_pkg::ADDR_W-1:PAGE_BITS];
      widx_q <= word_index;
    end
    if (cmd.drain_start) begin
      work <= rd_data;
    end else if (cmd.drain_emit) begin
      work <= rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr    <= '0;
      arena_pages <= NW'(32768);
      dirty_total <= '0;
    end else begin
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cfg_we) begin
        arena_pages <= cfg_data;
      end
      dirty_total <= total_next;
    end
  end

  assign load = cmd.mark_done || cmd.drain_empty || cmd.drain_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mark_done) begin
      page_number  <= page_ext[PW-1:0];
      page_valid   <= !oor;
      newly_dirty  <= fresh;
      out_of_range <= oor;
      dirty_count  <= total_next;
      last         <= 1'b1;
    end else if (cmd.drain_empty) begin
      page_number  <= '0;
      page_valid   <= 1'b0;
      newly_dirty  <= 1'b0;
      out_of_range <= 1'b0;
      dirty_count  <= total_next;
      last         <= 1'b1;
    end else if (cmd.drain_emit) begin
      page_number  <= drain_page[PW-1:0];
      page_valid   <= 1'b1;
      newly_dirty  <= 1'b0;
      out_of_range <= 1'b0;
      dirty_count  <= total_next;
      last         <= (rem == '0);
    end
  end

  assign sts.clear_done  = (clr_addr == CLR_LAST_C);
  assign sts.is_drain    = mode_q;
  assign sts.drain_empty = idx_oor || (rd_data == '0);
  assign sts.slot_free   = !out_valid || !out_stall;
  assign sts.work_last   = (rem == '0);

endmodule

// ===== rtl/dirty_page_tracker.sv =====
// Dirty page tracker top level: one dirty bit per page, mark and drain items.
// Mark: the word is read on acceptance and the result registered once the output slot is free.
// Drain: one result per cycle per dirty page while not stalled (empty drain: one result).
// Drain order: a lowest-set-bit pick on the held bitmap word, one page a cycle when not stalled.
// Reset: a sweep clears the bitmap memory, one word a cycle (ceil(MAX_PAGES / WORD_BITS) words,
// 512 by default) with in_stall high; arena_pages resets to 32768.
module dirty_page_tracker #(
  parameter int PAGE_BITS = 12,
  parameter int MAX_PAGES = 32768,
  parameter int WORD_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic [dpt_pkg::ADDR_W-1:0]    address,
  input  logic [dpt_pkg::WIDX_W-1:0]    word_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dpt_pkg::PAGE_NW-1:0]   page_number,
  output logic                          page_valid,
  output logic                          newly_dirty,
  output logic                          out_of_range,
  output logic [dpt_pkg::COUNT_W-1:0]   dirty_count,
  output logic                          last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dpt_pkg::COUNT_W-1:0]   arena_pages
);

  dpt_pkg::cmd_t cmd;
  dpt_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  dpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dpt_datapath #(
    .PAGE_BITS (PAGE_BITS),
    .MAX_PAGES (MAX_PAGES),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (arena_pages),
    .mode         (mode),
    .address      (address),
    .word_index   (word_index),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .page_number  (page_number),
    .page_valid   (page_valid),
    .newly_dirty  (newly_dirty),
    .out_of_range (out_of_range),
    .dirty_count  (dirty_count),
    .last         (last)
  );

endmodule

// ===== rtl/dpt_checker.sv =====
// Port-level checker of the dirty page tracker and its bind
`include "dirty_page_tracker_assert.svh"

module dpt_checker (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic page_valid,
  input logic newly_dirty,
  input logic out_of_range,
  input logic last
);

  `DPT_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
  `DPT_ASSERT_IMP(a_sweep_stall, $fell(rst), in_stall)
  `DPT_ASSERT_IMP(a_nopage_last, out_valid && !page_valid, last && !newly_dirty)
  `DPT_ASSERT_IMP(a_fresh_real, out_valid && newly_dirty, page_valid && !out_of_range)
  `DPT_ASSERT_IMP(a_oor_single, out_valid && out_of_range, !page_valid && last)

endmodule

bind dirty_page_tracker dpt_checker u_checker (.*);
